/* rtl/csam_pkg.sv */
`default_nettype none
package csam_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int MAX_NNZ_DEF = 1024;

	localparam int FUNC_W  = 3;
	localparam int ROW_W   = 6;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 3;
	localparam int DIMR_W  = 7;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [FUNC_W-1:0] FN_LOAD_A = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD_B = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SUM    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_PROD   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_DIM   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
	localparam logic [STAT_W-1:0] ST_ORDER = 3'd4;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	localparam logic [DIMR_W-1:0] DIM_RESET = 7'd64;

	typedef struct packed {
		logic [DIMR_W-1:0] a_rows;
		logic [DIMR_W-1:0] a_cols;
		logic [DIMR_W-1:0] b_rows;
		logic [DIMR_W-1:0] b_cols;
	} cfg_t;

	typedef struct packed {
		logic              capture;
		logic              ld_rd;
		logic              ld_wr;
		logic              clear_all;
		logic              acc_clear;
		logic              off_start;
		logic              off_b;
		logic              off_k;
		logic              off_rd;
		logic              off_step;
		logic              off_done;
		logic              a_rd;
		logic              b_rd;
		logic              a_take;
		logic              add_a;
		logic              add_b;
		logic              mul;
		logic              quant;
		logic              acc_rd;
		logic              acc_wr;
		logic              scan_start;
		logic              scan_rd;
		logic              scan_next;
		logic              emit;
		logic              result;
		logic [STAT_W-1:0] res_code;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [STAT_W-1:0] ld_code;
		logic              ld_keep;
		logic [STAT_W-1:0] cp_code;
		logic              off_hit;
		logic              off_b;
		logic              a_more;
		logic              b_more;
		logic              mask_any;
		logic              mask_bit;
		logic              out_free;
	} sts_t;

	// clamp a wide signed value to the 32 bit range
	function automatic logic [VAL_W-1:0] sat_val(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		else if (v < 48'shFFFF_8000_0000)
			return 32'h8000_0000;
		else
			return v[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/csam_store.sv */
`default_nettype none
module csam_store import csam_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int MAX_NNZ = MAX_NNZ_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM),
	localparam int CNT_W  = $clog2(MAX_NNZ + 1),
	localparam int ADDR_W = $clog2(MAX_NNZ)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              cnt_re,
	input  wire logic [DIM_W-1:0]  cnt_raddr,
	output logic      [CNT_W-1:0]  cnt_rdata,
	input  wire logic              inc,
	input  wire logic [DIM_W-1:0]  inc_row,
	input  wire logic [CNT_W-1:0]  inc_cnt,
	input  wire logic [DIM_W-1:0]  inc_col,
	input  wire logic [VAL_W-1:0]  inc_val,
	input  wire logic              el_re,
	input  wire logic [ADDR_W-1:0] el_raddr,
	output logic      [DIM_W-1:0]  el_col,
	output logic      [VAL_W-1:0]  el_val,
	output logic      [DIM_W-1:0]  last_row,
	output logic                   full
);

	logic [VAL_W-1:0] val_mem [MAX_NNZ];
	logic [DIM_W-1:0] col_mem [MAX_NNZ];
	logic [CNT_W-1:0] cnt_mem [MAX_DIM];

	logic [MAX_DIM-1:0] cnt_vld_q;
	logic               cnt_vld_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [DIM_W-1:0]   last_q;

	always_ff @(posedge clk) begin
		if (inc) begin
			val_mem[ADDR_W'(count_q)] <= inc_val;
			col_mem[ADDR_W'(count_q)] <= inc_col;
			cnt_mem[inc_row] <= inc_cnt;
		end
		if (el_re) begin
			el_val <= val_mem[el_raddr];
			el_col <= col_mem[el_raddr];
		end
		if (cnt_re)
			cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	// a row count that was never written since clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
			count_q      <= '0;
			last_q       <= '0;
		end else begin
			if (cnt_re)
				cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
			if (clear) begin
				cnt_vld_q <= '0;
				count_q   <= '0;
				last_q    <= '0;
			end else if (inc) begin
				cnt_vld_q[inc_row] <= 1'b1;
				count_q            <= count_q + CNT_W'(1);
				last_q             <= inc_row;
			end
		end
	end

	assign cnt_rdata = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign last_row  = last_q;
	assign full      = (32'(count_q) == MAX_NNZ);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_NNZ) else $error("element count beyond store depth");
	a_no_inc_full: assert property (@(posedge clk) disable iff (!arst_n)
		inc |-> !full) else $error("element stored into a full store");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (count_q == '0 && cnt_vld_q == '0)) else $error("clear left elements");
`endif

endmodule
`default_nettype wire

/* rtl/csam_ctrl.sv */
`default_nettype none
module csam_ctrl import csam_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DECODE  = 5'd1;
	localparam logic [4:0] S_LD_RD   = 5'd2;
	localparam logic [4:0] S_LD_WR   = 5'd3;
	localparam logic [4:0] S_RESULT  = 5'd4;
	localparam logic [4:0] S_OFF_RD  = 5'd5;
	localparam logic [4:0] S_OFF_ACC = 5'd6;
	localparam logic [4:0] S_A_CHK   = 5'd7;
	localparam logic [4:0] S_A_RD    = 5'd8;
	localparam logic [4:0] S_A_USE   = 5'd9;
	localparam logic [4:0] S_B_CHK   = 5'd10;
	localparam logic [4:0] S_B_RD    = 5'd11;
	localparam logic [4:0] S_B_USE   = 5'd12;
	localparam logic [4:0] S_MUL_Q   = 5'd13;
	localparam logic [4:0] S_ACC_RD  = 5'd14;
	localparam logic [4:0] S_ACC_WR  = 5'd15;
	localparam logic [4:0] S_SCAN    = 5'd16;
	localparam logic [4:0] S_EMIT    = 5'd17;

	logic [4:0]        state_q, state_d;
	logic              in_b_q, in_b_d;
	logic              sent_q, sent_d;
	logic [STAT_W-1:0] code_q, code_d;
	logic              is_sum;

	assign is_sum = (sts.func == FN_SUM);

	always_comb begin
		state_d  = state_q;
		in_b_d   = in_b_q;
		sent_d   = sent_q;
		code_d   = code_q;
		cmd      = '0;
		cmd.res_code = code_q;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					in_b_d      = 1'b0;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FN_LOAD_A, FN_LOAD_B: begin
						if (sts.ld_keep) begin
							state_d = S_LD_RD;
						end else begin
							code_d  = sts.ld_code;
							state_d = S_RESULT;
						end
					end
					FN_SUM, FN_PROD: begin
						if (sts.cp_code != ST_OK) begin
							code_d  = sts.cp_code;
							state_d = S_RESULT;
						end else begin
							cmd.acc_clear = 1'b1;
							cmd.off_start = 1'b1;
							state_d       = S_OFF_RD;
						end
					end
					FN_CLEAR: begin
						cmd.clear_all = 1'b1;
						code_d        = ST_OK;
						state_d       = S_RESULT;
					end
					default: begin
						code_d  = ST_OK;
						state_d = S_RESULT;
					end
				endcase
			end
			S_LD_RD: begin
				cmd.ld_rd = 1'b1;
				state_d   = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				code_d    = ST_OK;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_OFF_RD: begin
				cmd.off_rd = 1'b1;
				state_d    = S_OFF_ACC;
			end
			S_OFF_ACC: begin
				if (sts.off_hit) begin
					cmd.off_done = 1'b1;
					state_d      = sts.off_b ? S_B_CHK : S_A_CHK;
				end else begin
					cmd.off_step = 1'b1;
					state_d      = S_OFF_RD;
				end
			end
			S_A_CHK: begin
				if (sts.a_more) begin
					state_d = S_A_RD;
				end else if (is_sum) begin
					// A part of the row done, now the same row of B
					in_b_d        = 1'b1;
					cmd.off_start = 1'b1;
					cmd.off_b     = 1'b1;
					state_d       = S_OFF_RD;
				end else begin
					cmd.scan_start = 1'b1;
					sent_d         = 1'b0;
					state_d        = S_SCAN;
				end
			end
			S_A_RD: begin
				cmd.a_rd = 1'b1;
				state_d  = S_A_USE;
			end
			S_A_USE: begin
				if (is_sum) begin
					cmd.add_a = 1'b1;
					state_d   = S_ACC_RD;
				end else begin
					// walk the B row named by this A column
					cmd.a_take    = 1'b1;
					cmd.off_start = 1'b1;
					cmd.off_b     = 1'b1;
					cmd.off_k     = 1'b1;
					state_d       = S_OFF_RD;
				end
			end
			S_B_CHK: begin
				if (sts.b_more) begin
					state_d = S_B_RD;
				end else if (is_sum) begin
					cmd.scan_start = 1'b1;
					sent_d         = 1'b0;
					state_d        = S_SCAN;
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_B_RD: begin
				cmd.b_rd = 1'b1;
				state_d  = S_B_USE;
			end
			S_B_USE: begin
				if (is_sum) begin
					cmd.add_b = 1'b1;
					state_d   = S_ACC_RD;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_MUL_Q;
				end
			end
			S_MUL_Q: begin
				cmd.quant = 1'b1;
				state_d   = S_ACC_RD;
			end
			S_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d    = S_ACC_WR;
			end
			S_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				state_d    = (is_sum && !in_b_q) ? S_A_CHK : S_B_CHK;
			end
			S_SCAN: begin
				if (!sts.mask_any) begin
					if (sent_q) begin
						state_d = S_IDLE;
					end else begin
						code_d  = ST_OK;
						state_d = S_RESULT;
					end
				end else if (sts.mask_bit) begin
					cmd.scan_rd = 1'b1;
					state_d     = S_EMIT;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					sent_d   = 1'b1;
					state_d  = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_b_q  <= 1'b0;
			sent_q  <= 1'b0;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			in_b_q  <= in_b_d;
			sent_q  <= sent_d;
			code_q  <= code_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/csam_dp.sv */
`default_nettype none
module csam_dp import csam_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int MAX_NNZ = MAX_NNZ_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM),
	localparam int CNT_W  = $clog2(MAX_NNZ + 1),
	localparam int ADDR_W = $clog2(MAX_NNZ)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [ROW_W-1:0]  row,
	input  wire logic [ROW_W-1:0]  col,
	input  wire logic [VAL_W-1:0]  value,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [STAT_W-1:0]      status,
	output logic                   has_entry,
	output logic [ROW_W-1:0]       out_row,
	output logic [ROW_W-1:0]       out_col,
	output logic [VAL_W-1:0]       out_value,
	output logic                   last
);

	// captured word
	logic [FUNC_W-1:0] func_q;
	logic [ROW_W-1:0]  row_q, col_q;
	logic [VAL_W-1:0]  val_q;
	logic [DIM_W-1:0]  row_ix, col_ix;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			row_q  <= row;
			col_q  <= col;
			val_q  <= value;
		end
	end

	assign row_ix = DIM_W'(row_q);
	assign col_ix = DIM_W'(col_q);

	// matrix stores
	logic               sel_b;
	logic [CNT_W-1:0]   a_cnt_rdata, b_cnt_rdata;
	logic [DIM_W-1:0]   a_el_col, b_el_col, a_last, b_last;
	logic [VAL_W-1:0]   a_el_val, b_el_val;
	logic               a_full, b_full;
	logic [DIM_W-1:0]   cnt_raddr;
	logic               off_b_q, off_k_q;
	logic [DIM_W-1:0]   idx_q, k_q;
	logic [CNT_W-1:0]   off_q, cur_cnt;
	logic [CNT_W-1:0]   a_ptr_q, a_end_q, b_ptr_q, b_end_q;

	assign sel_b     = (func_q == FN_LOAD_B);
	assign cnt_raddr = cmd.ld_rd ? row_ix : idx_q;

	csam_store #(.MAX_DIM(MAX_DIM), .MAX_NNZ(MAX_NNZ)) u_store_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cmd.clear_all),
		.cnt_re    ((cmd.ld_rd && !sel_b) || (cmd.off_rd && !off_b_q)),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (a_cnt_rdata),
		.inc       (cmd.ld_wr && !sel_b),
		.inc_row   (row_ix),
		.inc_cnt   (a_cnt_rdata + CNT_W'(1)),
		.inc_col   (col_ix),
		.inc_val   (val_q),
		.el_re     (cmd.a_rd),
		.el_raddr  (ADDR_W'(a_ptr_q)),
		.el_col    (a_el_col),
		.el_val    (a_el_val),
		.last_row  (a_last),
		.full      (a_full)
	);

	csam_store #(.MAX_DIM(MAX_DIM), .MAX_NNZ(MAX_NNZ)) u_store_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cmd.clear_all),
		.cnt_re    ((cmd.ld_rd && sel_b) || (cmd.off_rd && off_b_q)),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (b_cnt_rdata),
		.inc       (cmd.ld_wr && sel_b),
		.inc_row   (row_ix),
		.inc_cnt   (b_cnt_rdata + CNT_W'(1)),
		.inc_col   (col_ix),
		.inc_val   (val_q),
		.el_re     (cmd.b_rd),
		.el_raddr  (ADDR_W'(b_ptr_q)),
		.el_col    (b_el_col),
		.el_val    (b_el_val),
		.last_row  (b_last),
		.full      (b_full)
	);

	// load checks, in priority order
	logic [DIMR_W-1:0] lim_rows, lim_cols;
	logic              ld_rng, ld_ord, ld_zero, ld_full;
	logic [STAT_W-1:0] ld_code, cp_code;
	logic              is_sum, dim_bad, cp_rng;

	always_comb begin
		lim_rows = sel_b ? cfg.b_rows : cfg.a_rows;
		lim_cols = sel_b ? cfg.b_cols : cfg.a_cols;
		ld_rng   = ({1'b0, row_q} >= lim_rows) || ({1'b0, col_q} >= lim_cols) ||
			(32'(row_q) >= MAX_DIM) || (32'(col_q) >= MAX_DIM);
		ld_ord   = row_ix < (sel_b ? b_last : a_last);
		ld_zero  = (val_q == '0);
		ld_full  = sel_b ? b_full : a_full;
		if (ld_rng)
			ld_code = ST_RANGE;
		else if (ld_ord)
			ld_code = ST_ORDER;
		else if (ld_zero)
			ld_code = ST_OK;
		else if (ld_full)
			ld_code = ST_FULL;
		else
			ld_code = ST_OK;

		is_sum  = (func_q == FN_SUM);
		dim_bad = is_sum ? (cfg.a_rows != cfg.b_rows || cfg.a_cols != cfg.b_cols)
			: (cfg.a_cols != cfg.b_rows);
		cp_rng  = ({1'b0, row_q} >= cfg.a_rows) || (32'(row_q) >= MAX_DIM);
		if (dim_bad)
			cp_code = ST_DIM;
		else if (cp_rng)
			cp_code = ST_RANGE;
		else
			cp_code = ST_OK;
	end

	// row offset sweep and element walk
	assign cur_cnt = off_b_q ? b_cnt_rdata : a_cnt_rdata;

	logic [VAL_W-1:0]        x_q, addend_q;
	logic [DIM_W-1:0]        acol_q;
	logic signed [2*VAL_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.off_start) begin
			off_q   <= '0;
			idx_q   <= '0;
			off_b_q <= cmd.off_b;
			off_k_q <= cmd.off_k;
		end else if (cmd.off_step) begin
			off_q <= off_q + cur_cnt;
			idx_q <= idx_q + DIM_W'(1);
		end
		if (cmd.off_done && !off_b_q) begin
			a_ptr_q <= off_q;
			a_end_q <= off_q + cur_cnt;
		end else if (cmd.a_rd) begin
			a_ptr_q <= a_ptr_q + CNT_W'(1);
		end
		if (cmd.off_done && off_b_q) begin
			b_ptr_q <= off_q;
			b_end_q <= off_q + cur_cnt;
		end else if (cmd.b_rd) begin
			b_ptr_q <= b_ptr_q + CNT_W'(1);
		end
		if (cmd.a_take) begin
			k_q <= a_el_col;
			x_q <= a_el_val;
		end
		if (cmd.mul) begin
			prod_s1 <= $signed(x_q) * $signed(b_el_val);
			acol_q  <= b_el_col;
		end
		if (cmd.add_a) begin
			addend_q <= a_el_val;
			acol_q   <= a_el_col;
		end else if (cmd.add_b) begin
			addend_q <= b_el_val;
			acol_q   <= b_el_col;
		end else if (cmd.quant) begin
			// drop the 16 fraction bits, rounding toward minus infinity
			addend_q <= sat_val(prod_s1[2*VAL_W-1:16]);
		end
	end

	// row accumulator
	logic [VAL_W-1:0]   acc_mem [MAX_DIM];
	logic [VAL_W-1:0]   acc_rd_q, acc_old, acc_new;
	logic signed [VAL_W:0] acc_sum;
	logic [MAX_DIM-1:0] touched_q, nz_q, mask_q, mask_rest;
	logic [DIM_W-1:0]   j_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_wr)
			acc_mem[acol_q] <= acc_new;
		if (cmd.acc_rd || cmd.scan_rd)
			acc_rd_q <= acc_mem[cmd.acc_rd ? acol_q : j_q];
	end

	always_comb begin
		acc_old = touched_q[acol_q] ? acc_rd_q : '0;
		acc_sum = $signed({acc_old[VAL_W-1], acc_old}) + $signed({addend_q[VAL_W-1], addend_q});
		acc_new = sat_val({{15{acc_sum[VAL_W]}}, acc_sum});
		mask_rest = mask_q;
		mask_rest[j_q] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
			nz_q      <= '0;
			mask_q    <= '0;
			j_q       <= '0;
		end else begin
			if (cmd.acc_clear || cmd.clear_all) begin
				touched_q <= '0;
				nz_q      <= '0;
			end else if (cmd.acc_wr) begin
				touched_q[acol_q] <= 1'b1;
				nz_q[acol_q]      <= (acc_new != '0);
			end
			if (cmd.scan_start) begin
				// sums that cancel to zero are dropped, products are kept
				mask_q <= touched_q & (is_sum ? nz_q : '1);
				j_q    <= '0;
			end else if (cmd.emit) begin
				mask_q <= mask_rest;
				j_q    <= j_q + DIM_W'(1);
			end else if (cmd.scan_next) begin
				j_q <= j_q + DIM_W'(1);
			end
		end
	end

	// output register
	logic out_valid_q, out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.result || cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			status    <= cmd.res_code;
			has_entry <= 1'b0;
			out_row   <= '0;
			out_col   <= '0;
			out_value <= '0;
			last      <= 1'b1;
		end else if (cmd.emit) begin
			status    <= ST_OK;
			has_entry <= 1'b1;
			out_row   <= row_q;
			out_col   <= ROW_W'(j_q);
			out_value <= acc_rd_q;
			last      <= (mask_rest == '0);
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts          = '0;
		sts.func     = func_q;
		sts.ld_code  = ld_code;
		sts.ld_keep  = !ld_rng && !ld_ord && !ld_zero && !ld_full;
		sts.cp_code  = cp_code;
		sts.off_hit  = (idx_q == (off_k_q ? k_q : row_ix));
		sts.off_b    = off_b_q;
		sts.a_more   = (a_ptr_q < a_end_q);
		sts.b_more   = (b_ptr_q < b_end_q);
		sts.mask_any = (mask_q != '0);
		sts.mask_bit = mask_q[j_q];
		sts.out_free = out_free;
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.result || cmd.emit) |-> out_free) else $error("output register overwritten");
	a_emit_touched: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (mask_q[j_q] && touched_q[j_q])) else $error("emit of untouched column");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.result || cmd.emit)) else $error("word with no source");
`endif

endmodule
`default_nettype wire

/* rtl/csr_sparse_add_multiply_unit.sv */
`default_nettype none
// Sparse matrix add and row-wise multiply on two matrices held in compressed-row
// form. Elements of A and B are loaded one word at a time in nondecreasing row
// order; a compute word then streams out one row of A+B or A*B in ascending
// column order with the last flag on its final entry, Q16.16 with saturation.
// One word is worked on at a time. A stored load is checked, reads its row count
// and writes the element and the raised count; a rejected load gets its status
// from the checks alone; both wait while the output is full. A sum sweeps the A
// row counts to its row, adds each element into the accumulator by a read and a
// write, does the same for B, then scans the columns. A product, for each A
// element with column k, sweeps the B row counts to row k, then multiplies,
// quantizes and accumulates each B element of that row, then scans likewise. No
// clearing pass is needed after reset. Dimension registers sit at byte addresses
// 0, 4, 8 and 12; the user must write them only while the block is idle (unchecked).
module csr_sparse_add_multiply_unit import csam_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int MAX_NNZ = MAX_NNZ_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [ROW_W-1:0]   row,
	input  wire logic [ROW_W-1:0]   col,
	input  wire logic [VAL_W-1:0]   value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [STAT_W-1:0]       status,
	output logic                    has_entry,
	output logic [ROW_W-1:0]        out_row,
	output logic [ROW_W-1:0]        out_col,
	output logic [VAL_W-1:0]        out_value,
	output logic                    last
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_rows <= DIM_RESET;
			cfg_q.a_cols <= DIM_RESET;
			cfg_q.b_rows <= DIM_RESET;
			cfg_q.b_cols <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_A_ROWS: cfg_q.a_rows <= pwdata[DIMR_W-1:0];
				REG_A_COLS: cfg_q.a_cols <= pwdata[DIMR_W-1:0];
				REG_B_ROWS: cfg_q.b_rows <= pwdata[DIMR_W-1:0];
				REG_B_COLS: cfg_q.b_cols <= pwdata[DIMR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_A_ROWS: prdata = PDATA_W'(cfg_q.a_rows);
			REG_A_COLS: prdata = PDATA_W'(cfg_q.a_cols);
			REG_B_ROWS: prdata = PDATA_W'(cfg_q.b_rows);
			REG_B_COLS: prdata = PDATA_W'(cfg_q.b_cols);
			default:    prdata = '0;
		endcase
	end

	csam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csam_dp #(.MAX_DIM(MAX_DIM), .MAX_NNZ(MAX_NNZ)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.func      (func),
		.row       (row),
		.col       (col),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.has_entry (has_entry),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last)
	);

endmodule
`default_nettype wire

/* tb/csr_sparse_add_multiply_unit_test.sv */
module csr_sparse_add_multiply_unit_test;
	import csam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NNZ = 1024;
	localparam int DIM = 64;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef enum int {K_WORD, K_CFG, K_DRAIN} pend_kind_t;

	typedef struct {
		pend_kind_t        kind;
		logic [FUNC_W-1:0] f;
		logic [ROW_W-1:0]  r;
		logic [ROW_W-1:0]  c;
		logic [VAL_W-1:0]  v;
		logic [1:0]        idx;
		logic [31:0]       data;
	} pend_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic              has_entry;
		logic [ROW_W-1:0]  out_row;
		logic [ROW_W-1:0]  out_col;
		logic [VAL_W-1:0]  out_value;
		logic              last;
	} row_entry_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 0;
	logic               in_stall;
	logic [FUNC_W-1:0]  func = '0;
	logic [ROW_W-1:0]   row = '0;
	logic [ROW_W-1:0]   col = '0;
	logic [VAL_W-1:0]   value = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic [STAT_W-1:0]  status;
	logic               has_entry;
	logic [ROW_W-1:0]   out_row;
	logic [ROW_W-1:0]   out_col;
	logic [VAL_W-1:0]   out_value;
	logic               last;

	csr_sparse_add_multiply_unit uut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// shadow of the matrix stores, index 0 is A and 1 is B
	logic signed [31:0] mat_val [2][NNZ];
	logic [5:0]         mat_col [2][NNZ];
	int                 mat_row_cnt [2][DIM];
	int                 mat_cnt [2];
	int                 mat_last_row [2];
	int                 dims [4];
	logic signed [31:0] row_acc [DIM];
	bit                 row_touched [DIM];

	pend_t      pending [$];
	row_entry_t expected_row [$];
	int         errors = 0;
	longint     cycles = 0;
	int         words_sent = 0, results_seen = 0, entries_seen = 0;
	int         func_seen [8];
	int         status_seen [8];
	bit         in_took = 0;
	int         in_gap = 0, out_hold = 0;
	bit         quiet = 0;
	int         words_queued = 0;

	function automatic logic signed [31:0] sat_q(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic void acc_add(int c, logic signed [31:0] v);
		if (!row_touched[c]) begin
			row_touched[c] = 1;
			row_acc[c] = 0;
		end
		row_acc[c] = sat_q(longint'(row_acc[c]) + longint'(v));
	endfunction

	function automatic int first_of_row(int m, int r);
		int s;
		s = 0;
		for (int i = 0; i < r; i++) s += mat_row_cnt[m][i];
		return s;
	endfunction

	function automatic void push_status(logic [STAT_W-1:0] st);
		row_entry_t e;
		e = '{st, 1'b0, '0, '0, '0, 1'b1};
		expected_row = {expected_row, e};
	endfunction

	function automatic logic [STAT_W-1:0] load_elem(int m, int r, int c,
			logic signed [31:0] v);
		if (r >= dims[2*m] || c >= dims[2*m+1]) return ST_RANGE;
		if (r < mat_last_row[m]) return ST_ORDER;
		if (v == 0) return ST_OK;
		if (mat_cnt[m] >= NNZ) return ST_FULL;
		mat_val[m][mat_cnt[m]] = v;
		mat_col[m][mat_cnt[m]] = c;
		mat_row_cnt[m][r]++;
		mat_cnt[m]++;
		mat_last_row[m] = r;
		return ST_OK;
	endfunction

	function automatic void predict_word(logic [FUNC_W-1:0] f, int r, int c,
			logic signed [31:0] v);
		row_entry_t e;
		int s, n, k, bs;
		longint p;
		bit is_sum;
		is_sum = (f == FN_SUM);
		case (f)
			FN_LOAD_A: push_status(load_elem(0, r, c, v));
			FN_LOAD_B: push_status(load_elem(1, r, c, v));
			FN_SUM, FN_PROD: begin
				if (is_sum ? (dims[0] != dims[2] || dims[1] != dims[3])
						: (dims[1] != dims[2]))
					push_status(ST_DIM);
				else if (r >= dims[0])
					push_status(ST_RANGE);
				else begin
					for (int j = 0; j < DIM; j++) row_touched[j] = 0;
					if (is_sum) begin
						for (int m = 0; m < 2; m++) begin
							s = first_of_row(m, r);
							for (int j = s; j < s + mat_row_cnt[m][r]; j++)
								acc_add(mat_col[m][j], mat_val[m][j]);
						end
					end else begin
						s = first_of_row(0, r);
						for (int j = s; j < s + mat_row_cnt[0][r]; j++) begin
							k = mat_col[0][j];
							bs = first_of_row(1, k);
							for (int i = bs; i < bs + mat_row_cnt[1][k]; i++) begin
								p = longint'(mat_val[0][j]) * longint'(mat_val[1][i]);
								acc_add(mat_col[1][i], sat_q(p >>> 16));
							end
						end
					end
					n = 0;
					for (int j = 0; j < DIM; j++) begin
						if (!row_touched[j] || (is_sum && row_acc[j] == 0)) continue;
						e = '{ST_OK, 1'b1, r[5:0], j[5:0], row_acc[j], 1'b0};
						expected_row = {expected_row, e};
						n++;
					end
					if (n > 0) expected_row[$].last = 1'b1;
					else push_status(ST_OK);
				end
			end
			FN_CLEAR: begin
				for (int m = 0; m < 2; m++) begin
					for (int i = 0; i < DIM; i++) mat_row_cnt[m][i] = 0;
					mat_cnt[m] = 0;
					mat_last_row[m] = 0;
				end
				push_status(ST_OK);
			end
			default: push_status(ST_OK);
		endcase
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// sampling side: predicts accepted words and checks accepted results
	always @(posedge clk) begin
		row_entry_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_word(func, row, col, value);
				func_seen[func]++;
				words_sent++;
				in_took = 1;
				if (words_sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				status_seen[status]++;
				if (has_entry) entries_seen++;
				if (expected_row.size() == 0) begin
					$error("unexpected result word, status %0d", status);
					errors++;
				end else begin
					e = expected_row.pop_front();
					check_field("status", e.status, status);
					check_field("has_entry", e.has_entry, has_entry);
					check_field("out_row", e.out_row, out_row);
					check_field("out_col", e.out_col, out_col);
					check_field("out_value", e.out_value, out_value);
					check_field("last", e.last, last);
				end
				out_hold = quiet ? 0 : $urandom_range(0, 14);
			end
		end
	end

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_stall <= 1;
			out_hold--;
		end else
			out_stall <= 0;
	end

	// waits for the block to go idle, then optionally writes a register
	task automatic settle_and_write(pend_t p);
		while (expected_row.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (p.kind == K_CFG) begin
			psel <= 1;
			pwrite <= 1;
			paddr <= PADDR_W'(p.idx * 4);
			pwdata <= p.data;
			@(negedge clk) penable <= 1;
			@(negedge clk);
			psel <= 0;
			penable <= 0;
			pwrite <= 0;
			dims[p.idx] = p.data & 32'd127;
		end
	endtask

	always @(negedge clk) begin
		pend_t p;
		if (arst_n) begin
			if (in_valid && !in_took) begin
				// stalled word stays put
			end else if (in_gap > 0) begin
				in_valid <= 0;
				in_gap--;
			end else if (pending.size() > 0) begin
				p = pending.pop_front();
				if (p.kind == K_WORD) begin
					func <= p.f;
					row <= p.r;
					col <= p.c;
					value <= p.v;
					in_valid <= 1;
					in_gap = quiet ? 0 : $urandom_range(0, 14);
				end else begin
					in_valid <= 0;
					settle_and_write(p);
				end
			end else
				in_valid <= 0;
			in_took = 0;
		end
	end

	function automatic void push_word(logic [FUNC_W-1:0] f, int r, int c, logic [31:0] v);
		pend_t p;
		p = '{K_WORD, f, r[5:0], c[5:0], v, 2'd0, 32'd0};
		pending = {pending, p};
		words_queued++;
	endfunction

	function automatic void push_cfg(logic [1:0] idx, logic [31:0] data);
		pend_t p;
		p = '{K_CFG, FN_CLEAR, 6'd0, 6'd0, 32'd0, idx, data};
		pending = {pending, p};
	endfunction

	function automatic void push_drain();
		pend_t p;
		p = '{K_DRAIN, FN_CLEAR, 6'd0, 6'd0, 32'd0, 2'd0, 32'd0};
		pending = {pending, p};
	endfunction

	function automatic void push_dims(int ar, int ac, int br, int bc);
		push_cfg(REG_A_ROWS, ar);
		push_cfg(REG_A_COLS, ac);
		push_cfg(REG_B_ROWS, br);
		push_cfg(REG_B_COLS, bc);
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom;
			default: return $urandom_range(1, 32'h8_0000) - 32'h4_0000;
		endcase
	endfunction

	// well-formed sparse load of one matrix, with some broken words mixed in
	function automatic void load_matrix(logic [FUNC_W-1:0] f, int nr, int nc);
		for (int r = 0; r < nr; r++) begin
			if ($urandom_range(0, 99) >= 20 + 60 / nr) continue;
			for (int n = $urandom_range(1, 3); n > 0; n--) begin
				case ($urandom_range(0, 19))
					0: push_word(f, r, $urandom_range(0, nc - 1), 0);
					1: push_word(f, r, nc < DIM ? $urandom_range(nc, 63) : 63,
						rand_q());
					2: push_word(f, $urandom_range(0, r), $urandom_range(0, nc - 1),
						rand_q());
					3: push_word(FUNC_W'($urandom_range(5, 7)), $urandom, $urandom,
						$urandom);
					default: push_word(f, r, $urandom_range(0, nc - 1), rand_q());
				endcase
			end
		end
	endfunction

	initial begin
		int ar, ac, br, bc, k;
		for (int i = 0; i < 4; i++) dims[i] = DIM_RESET;
		for (int m = 0; m < 2; m++) begin
			for (int i = 0; i < DIM; i++) mat_row_cnt[m][i] = 0;
			mat_cnt[m] = 0;
			mat_last_row[m] = 0;
		end
		for (int i = 0; i < 8; i++) begin
			func_seen[i] = 0;
			status_seen[i] = 0;
		end

		// directed: extremes, saturation, every function and every status but full
		push_word(FN_LOAD_A, 0, 0, 32'h7FFF_FFFF);
		push_word(FN_LOAD_A, 0, 63, 32'h8000_0000);
		push_word(FN_LOAD_A, 0, 5, 0);
		push_word(FN_LOAD_A, 63, 63, 32'h0001_0000);
		push_word(FN_LOAD_A, 10, 0, 5);
		push_word(FN_LOAD_B, 0, 0, 32'h7FFF_FFFF);
		push_word(FN_LOAD_B, 63, 0, 32'hFFFF_FFFF);
		push_word(FN_LOAD_B, 63, 0, 32'hFFFF_FFFF);
		push_word(FN_SUM, 0, 0, 0);
		push_word(FN_PROD, 0, 0, 0);
		push_word(FN_PROD, 63, 0, 0);
		push_word(FN_SUM, 5, 0, 0);
		push_word(3'd5, 63, 63, 32'hFFFF_FFFF);
		push_word(3'd6, 0, 0, 0);
		push_word(3'd7, 42, 21, 32'h5555_5555);
		push_dims(1, 127, 127, 1);
		push_word(FN_SUM, 0, 0, 0);
		push_word(FN_PROD, 0, 0, 0);
		push_word(FN_LOAD_A, 3, 0, 7);
		push_dims(1, 64, 64, 64);
		push_word(FN_PROD, 5, 0, 0);
		push_word(FN_PROD, 0, 0, 0);
		push_word(FN_CLEAR, 0, 0, 0);
		push_word(FN_SUM, 0, 0, 0);

		push_dims(64, 64, 64, 64);
		push_word(FN_SUM, 60, 0, 0);
		push_word(FN_LOAD_B, 60, 7, 32'h0002_0000);
		push_word(FN_PROD, 0, 0, 0);
		push_word(FN_CLEAR, 0, 0, 0);

		while (words_queued < 360) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					k = $urandom_range(1, 64);
					ar = k; ac = k; br = k; bc = k;
				end
				3, 4: begin
					ar = $urandom_range(1, 64);
					ac = $urandom_range(1, 64);
					br = ac;
					bc = $urandom_range(1, 64);
				end
				5: begin
					ar = 1; ac = 1; br = 1; bc = 1;
				end
				default: begin
					ar = 64; ac = 64; br = 64; bc = 64;
				end
			endcase
			push_dims(ar, ac, br, bc);
			push_word(FN_CLEAR, 0, 0, 0);
			load_matrix(FN_LOAD_A, ar, ac);
			load_matrix(FN_LOAD_B, br, bc);
			for (int i = 0; i < 8; i++) begin
				push_word($urandom_range(0, 1) ? FN_SUM : FN_PROD,
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
						: $urandom_range(0, ar - 1), $urandom, $urandom);
			end
			if ($urandom_range(0, 3) == 0) push_drain();
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		while (pending.size() > 0 || in_valid || expected_row.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d words sent (A loads %0d, B loads %0d, sums %0d, products %0d, clears %0d)",
			words_sent, func_seen[FN_LOAD_A], func_seen[FN_LOAD_B], func_seen[FN_SUM],
			func_seen[FN_PROD], func_seen[FN_CLEAR]);
		$display("%0d results checked, %0d row entries, status ok/dim/full/range/order %0d/%0d/%0d/%0d/%0d",
			results_seen, entries_seen, status_seen[ST_OK], status_seen[ST_DIM],
			status_seen[ST_FULL], status_seen[ST_RANGE], status_seen[ST_ORDER]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
